[hdl/sort_then_triple_search_unit_macros.svh]
// Assertion macros for the sort-then-triple-search unit.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef SORT_THEN_TRIPLE_SEARCH_UNIT_MACROS_SVH
`define SORT_THEN_TRIPLE_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STS_ASSERT(lbl, clk, rst_n, prop, msg)
`define STS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/sts_pkg.sv]
// Shared constants and types for the sort-then-triple-search unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sts_pkg;

	localparam int DEPTH_DEFAULT = 32;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// status codes carried in the output tuser
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_ZERO     = 2'd2;

	// largest magnitude that can still be tripled in 32-bit signed
	localparam logic signed [31:0] TRIPLE_MAX = 32'sd715827882;
	localparam logic signed [31:0] TRIPLE_MIN = -32'sd715827882;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

[hdl/sts_cmp.sv]
// Shared signed comparator used by both the sort passes and the search steps.
// Depends on sts_pkg for the result struct.
`timescale 1ns / 1ps
module sts_cmp
	import sts_pkg::*;
(
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output cmp_res_t           res
);

	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

[hdl/sts_mem.sv]
// Element store: one write port, one read port with registered read data.
// Depends on sts_pkg only through the common import.
`timescale 1ns / 1ps
module sts_mem
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [31:0]       wdata,
	input  logic [AW-1:0]     raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/sts_ctrl.sv]
// Sequencer: command decode, bubble-sort passes, repeated binary search and result register.
// Depends on sts_pkg and the assertion macros; drives sts_mem and sts_cmp.
`timescale 1ns / 1ps
`include "sort_then_triple_search_unit_macros.svh"
module sts_ctrl
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [31:0]        mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  logic [31:0]        mem_rdata,
	output logic signed [31:0] cmp_a,
	output logic signed [31:0] cmp_b,
	input  cmp_res_t           cmp_res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PASS,
		S_FIRST,
		S_CMP,
		S_TAIL,
		S_SRCH,
		S_SCMP,
		S_HOLD
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               sorted_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      lim_q;
	logic [31:0]        cur_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [AW-1:0]      mid_q;
	logic signed [31:0] key_q;
	logic [1:0]         stat_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;
	logic [1:0]         out_user_q;

	logic               accept;
	logic               has_room;
	logic [CW-1:0]      cnt_m1;
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid_w;
	logic [31:0]        rd_small;
	logic [31:0]        rd_large;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign has_room = (count_q < CW'(DEPTH));
	assign cnt_m1   = count_q - CW'(1);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w    = mid_sum[CW:1];

	// one bubble step: the smaller value settles, the larger one carries on
	assign rd_small = cmp_res.lt ? mem_rdata : cur_q;
	assign rd_large = cmp_res.lt ? cur_q : mem_rdata;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = s_tdata;
		mem_raddr = '0;
		cmp_a     = key_q;
		cmp_b     = $signed(mem_rdata);
		unique case (state_q)
			S_IDLE: begin
				mem_we = accept && (s_tuser == CMD_APPEND) && has_room;
			end
			S_FIRST: begin
				mem_raddr = AW'(1);
			end
			S_CMP: begin
				mem_raddr = k_q + AW'(2);
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = rd_small;
				cmp_a     = $signed(mem_rdata);
				cmp_b     = $signed(cur_q);
			end
			S_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = lim_q;
				mem_wdata = cur_q;
			end
			S_SRCH: begin
				mem_raddr = mid_w[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sorted_q    <= 1'b1;
			k_q         <= '0;
			lim_q       <= '0;
			cur_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			key_q       <= '0;
			stat_q      <= STAT_OK;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= STAT_OK;
		end else begin
			// S_HOLD reloads the output register itself
			if (out_valid_q && m_tready && (state_q != S_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (s_tuser == CMD_CLEAR) begin
							count_q  <= '0;
							sorted_q <= 1'b1;
						end else if (s_tuser == CMD_APPEND) begin
							if (has_room) begin
								count_q  <= count_q + CW'(1);
								sorted_q <= 1'b0;
							end
						end else if (s_tuser == CMD_QUERY) begin
							key_q    <= $signed(s_tdata);
							stat_q   <= STAT_OK;
							sorted_q <= 1'b1;
							lo_q     <= '0;
							hi_q     <= count_q;
							if (!sorted_q && (count_q >= CW'(2))) begin
								lim_q   <= cnt_m1[AW-1:0];
								state_q <= S_PASS;
							end else begin
								state_q <= S_SRCH;
							end
						end else begin
							// drop the unused command code
						end
					end
				end
				S_PASS: begin
					k_q     <= '0;
					state_q <= S_FIRST;
				end
				S_FIRST: begin
					cur_q   <= mem_rdata;
					state_q <= S_CMP;
				end
				S_CMP: begin
					cur_q <= rd_large;
					if (k_q + AW'(1) == lim_q) begin
						state_q <= S_TAIL;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_TAIL: begin
					lim_q <= lim_q - AW'(1);
					if (lim_q == AW'(1)) begin
						state_q <= S_SRCH;
					end else begin
						state_q <= S_PASS;
					end
				end
				S_SRCH: begin
					if (lo_q >= hi_q) begin
						state_q <= S_HOLD;
					end else begin
						mid_q   <= mid_w[AW-1:0];
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (cmp_res.eq) begin
						priority if (key_q == 32'sd0) begin
							stat_q  <= STAT_ZERO;
							state_q <= S_HOLD;
						end else if ((key_q > TRIPLE_MAX) || (key_q < TRIPLE_MIN)) begin
							stat_q  <= STAT_OVERFLOW;
							state_q <= S_HOLD;
						end else begin
							// triple and search the whole store again
							key_q   <= key_q + (key_q <<< 1);
							lo_q    <= '0;
							hi_q    <= count_q;
							state_q <= S_SRCH;
						end
					end else if (cmp_res.lt) begin
						hi_q    <= CW'(mid_q);
						state_q <= S_SRCH;
					end else begin
						lo_q    <= CW'(mid_q) + CW'(1);
						state_q <= S_SRCH;
					end
				end
				S_HOLD: begin
					// hold the result until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= key_q;
						out_user_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`STS_NEVER(a_count_bound, clk, arst_n, count_q > CW'(DEPTH),
		"element count beyond depth")
	`STS_NEVER(a_tail_lim, clk, arst_n, (state_q == S_TAIL) && (lim_q == '0),
		"sort tail with zero limit")
	`STS_ASSERT(a_srch_range, clk, arst_n,
		(state_q == S_SRCH) |-> ((lo_q <= hi_q) && (hi_q <= count_q)),
		"search window out of range")
	`STS_ASSERT(a_zero_result, clk, arst_n,
		(out_valid_q && (out_user_q == STAT_ZERO)) |-> (out_data_q == 32'd0),
		"zero status with non-zero value")
	`STS_ASSERT(a_ovf_result, clk, arst_n,
		(out_valid_q && (out_user_q == STAT_OVERFLOW)) |->
		(($signed(out_data_q) > TRIPLE_MAX) || ($signed(out_data_q) < TRIPLE_MIN)),
		"overflow status on a value that can be tripled")

endmodule

[hdl/sort_then_triple_search_unit.sv]
// Channel     | dir | tdata                  | tuser
// s_*         | in  | [31:0] value           | [1:0] cmd (0 clear, 1 append, 2 query)
// m_*         | out | [31:0] final_value     | [1:0] status (0 ok, 1 overflow, 2 zero)
//
// Clear and append are handled in S_IDLE itself. A query, on an unsorted store of n entries,
// first runs n-1 bubble passes (S_PASS, S_FIRST, S_CMP, S_TAIL) through the single memory
// read port and the shared comparator. Each search round steps through S_SRCH and S_SCMP per
// halving step, a round that misses ends in S_HOLD, and S_HOLD loads the result.
// Reset clears the count and marks the store sorted; element contents are not cleared.
// A finished result waits while the output register is still full; s_tready stays low then.
//
// Top level of the sort-then-triple-search unit; depends on sts_pkg, sts_cmp, sts_mem, sts_ctrl.
`timescale 1ns / 1ps
module sort_then_triple_search_unit
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] final_value
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [31:0]        mem_rdata;
	logic signed [31:0] cmp_a;
	logic signed [31:0] cmp_b;
	cmp_res_t           cmp_res;

	sts_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_res   (cmp_res)
	);

	sts_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sts_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

endmodule
